@@ design/assert_macros.svh @@
// Assertion macros shared by the tachometer RTL.
// Simulation builds see concurrent assertions; synthesis builds see nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MCPT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

`define MCPT_ASSERT_NEVER(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
        else $error("forbidden condition seen");

`else

`define MCPT_ASSERT(label, clk, rstn, prop)

`define MCPT_ASSERT_NEVER(label, clk, rstn, prop)

`endif

`endif

@@ design/mcpt_pkg.sv @@
package mcpt_pkg;

    localparam int CHANNELS = 5;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CHAN_W = 3;
    localparam int TIME_W = 32;
    localparam int RPM_W  = 16;
    localparam int PPR_W  = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [PPR_W-1:0]  PPR_RESET     = 8'd4;
    localparam logic [TIME_W-1:0] RPM_NUMERATOR = 32'd60000000;
    localparam logic [RPM_W-1:0]  RPM_MAX       = 16'hFFFF;

    // Periods at or below this limit give a quotient above the rpm range.
    localparam logic [TIME_W-1:0] SAT_LIMIT =
        RPM_NUMERATOR / (32'(RPM_MAX) + 32'd1);

    localparam int NUM_BITS = $clog2(int'(RPM_NUMERATOR) + 1);
    localparam int STEP_W   = $clog2(NUM_BITS);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/mcpt_div.sv @@
// Restoring divider: the fixed rpm numerator over a 32-bit period, one
// quotient bit per cycle. Only the low quotient bits are kept because the
// caller starts it only when the quotient fits the rpm field.
module mcpt_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mcpt_pkg::TIME_W-1:0]   divisor,
    output mcpt_pkg::div_stat_t           stat,
    output logic [mcpt_pkg::RPM_W-1:0]    quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [mcpt_pkg::STEP_W-1:0]     step_reg;
    logic [mcpt_pkg::TIME_W-1:0]     rem_reg;
    logic [mcpt_pkg::TIME_W-1:0]     dvs_reg;
    logic [mcpt_pkg::NUM_BITS-1:0]   num_reg;
    logic [mcpt_pkg::RPM_W-1:0]      quo_reg;

    logic [mcpt_pkg::TIME_W:0]       shifted;
    logic [mcpt_pkg::TIME_W:0]       diff;
    logic                            fits;
    logic [mcpt_pkg::TIME_W-1:0]     rem_next;
    logic                            last_step;

    always_comb begin
        shifted   = {rem_reg, num_reg[mcpt_pkg::NUM_BITS-1]};
        diff      = shifted - {1'b0, dvs_reg};
        fits      = !diff[mcpt_pkg::TIME_W];
        rem_next  = fits ? diff[mcpt_pkg::TIME_W-1:0] : shifted[mcpt_pkg::TIME_W-1:0];
        last_step = (step_reg == mcpt_pkg::STEP_W'(mcpt_pkg::NUM_BITS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && last_step) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            num_reg  <= mcpt_pkg::RPM_NUMERATOR[mcpt_pkg::NUM_BITS-1:0];
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            rem_reg  <= rem_next;
            num_reg  <= {num_reg[mcpt_pkg::NUM_BITS-2:0], 1'b0};
            quo_reg  <= {quo_reg[mcpt_pkg::RPM_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ design/multi_channel_pulse_tachometer.sv @@
// Multi-channel pulse tachometer.
// The s_ channel takes one pulse word per edge: the channel number and a
// free-running microsecond timestamp. Each channel counts pulses; when a pulse
// arrives with the count equal to pulses_per_rev, the revolution is complete
// and one result word goes out on the m_ channel: the channel, the rpm
// (60000000 over the period, capped at 65535) and a saturation flag in tuser.
// Pulses for channels beyond the last one are taken and dropped.
// cfg_we writes pulses_per_rev from cfg_wdata; write it only while idle.
// A pulse with a saturated period goes to the hold registers and from there
// to the output register; any other revolution first takes the 26 steps of
// the shared serial divider. A pulse without a result leaves the block ready
// for the next pulse. The block takes one pulse at a time and accepts the
// next once the result is in the output register.
// While the receiver stalls, a finished result waits in the output register;
// one more pulse may be taken and processed, and its result then holds the
// block until the output register frees.
// Reset clears all counts and revolution times and sets pulses_per_rev to 4.
`include "assert_macros.svh"

module multi_channel_pulse_tachometer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mcpt_pkg::S_TDATA_W-1:0]    s_tdata,   // channel, time_us
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mcpt_pkg::M_TDATA_W-1:0]    m_tdata,   // out_channel, rpm
    output logic [0:0]                        m_tuser,   // saturated
    input  logic                              cfg_we,
    input  logic [mcpt_pkg::PPR_W-1:0]        cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [mcpt_pkg::PPR_W-1:0]       ppr_reg;
    logic [mcpt_pkg::PPR_W-1:0]       cnt_reg  [mcpt_pkg::CHANNELS];
    logic [mcpt_pkg::TIME_W-1:0]      last_reg [mcpt_pkg::CHANNELS];

    logic [mcpt_pkg::CHAN_W-1:0]      hold_chan_reg;
    logic [mcpt_pkg::RPM_W-1:0]       hold_rpm_reg;
    logic                             hold_sat_reg;

    logic                             m_valid_reg;
    logic [mcpt_pkg::CHAN_W-1:0]      m_chan_reg;
    logic [mcpt_pkg::RPM_W-1:0]       m_rpm_reg;
    logic                             m_sat_reg;

    logic [mcpt_pkg::CHAN_W-1:0]      in_chan;
    logic [mcpt_pkg::TIME_W-1:0]      in_time;
    logic [mcpt_pkg::CH_IDX_W-1:0]    idx;
    logic                             chan_ok;
    logic                             accept;
    logic                             rev_hit;
    logic                             rev_start;
    logic [mcpt_pkg::TIME_W-1:0]      period;
    logic                             short_period;
    logic                             out_free;

    mcpt_pkg::div_stat_t              div_stat;
    logic [mcpt_pkg::RPM_W-1:0]       div_quo;

    always_comb begin
        in_chan      = s_tdata[mcpt_pkg::CHAN_W-1:0];
        in_time      = s_tdata[mcpt_pkg::CHAN_W+mcpt_pkg::TIME_W-1:mcpt_pkg::CHAN_W];
        idx          = in_chan[mcpt_pkg::CH_IDX_W-1:0];
        chan_ok      = {1'b0, in_chan} < (mcpt_pkg::CHAN_W + 1)'(mcpt_pkg::CHANNELS);
        accept       = s_tvalid && s_tready;
        rev_hit      = (cnt_reg[idx] == ppr_reg);
        rev_start    = accept && chan_ok && rev_hit;
        period       = in_time - last_reg[idx];
        short_period = (period <= mcpt_pkg::SAT_LIMIT);
        out_free     = !m_valid_reg || m_tready;
    end

    mcpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rev_start && !short_period),
        .divisor  (period),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (rev_start) begin
                    state_next = short_period ? ST_LOAD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ppr_reg     <= mcpt_pkg::PPR_RESET;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < mcpt_pkg::CHANNELS; i++) begin
                cnt_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                ppr_reg <= cfg_wdata;
            end
            if (accept && chan_ok) begin
                if (rev_hit) begin
                    cnt_reg[idx]  <= mcpt_pkg::PPR_W'(1);
                    last_reg[idx] <= in_time;
                end else begin
                    cnt_reg[idx] <= cnt_reg[idx] + 1'b1;
                end
            end
            if (state_reg == ST_LOAD && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rev_start) begin
            hold_chan_reg <= in_chan;
            hold_rpm_reg  <= mcpt_pkg::RPM_MAX;
            hold_sat_reg  <= short_period;
        end else if (state_reg == ST_DIV && div_stat.done) begin
            hold_rpm_reg <= div_quo;
        end
        if (state_reg == ST_LOAD && out_free) begin
            m_chan_reg <= hold_chan_reg;
            m_rpm_reg  <= hold_rpm_reg;
            m_sat_reg  <= hold_sat_reg;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {{(mcpt_pkg::M_TDATA_W - mcpt_pkg::RPM_W - mcpt_pkg::CHAN_W){1'b0}},
                         m_rpm_reg, m_chan_reg};
    assign m_tuser[0] = m_sat_reg;

    `MCPT_ASSERT(a_done_only_in_div, aclk, aresetn, div_stat.done |-> (state_reg == ST_DIV))
    `MCPT_ASSERT(a_div_runs_in_div, aclk, aresetn, (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
    `MCPT_ASSERT(a_short_skips_div, aclk, aresetn, (rev_start && short_period) |=> (state_reg == ST_LOAD && hold_sat_reg))
    `MCPT_ASSERT(a_sat_gives_max, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_rpm_reg == mcpt_pkg::RPM_MAX))

endmodule

@@ tb/sv/multi_channel_pulse_tachometer_tb.sv @@
module multi_channel_pulse_tachometer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    // Once the result queue empties no revolution is left in the block; the
    // bench still waits SETTLE_CYCLES before a register write.
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [mcpt_pkg::CHAN_W-1:0] channel;
        logic [mcpt_pkg::RPM_W-1:0]  rpm;
        logic                        saturated;
    } rev_result_t;

    class rpm_scoreboard;
        logic [mcpt_pkg::PPR_W-1:0]  ppr;
        logic [mcpt_pkg::PPR_W-1:0]  pulse_cnt [mcpt_pkg::CHANNELS];
        logic [mcpt_pkg::TIME_W-1:0] rev_time [mcpt_pkg::CHANNELS];
        rev_result_t                 expected_revs [$];
        int                          errors;

        function new();
            ppr    = mcpt_pkg::PPR_RESET;
            errors = 0;
            foreach (pulse_cnt[i]) begin
                pulse_cnt[i] = '0;
                rev_time[i]  = '0;
            end
        endfunction

        function void note_pulse(logic [mcpt_pkg::CHAN_W-1:0] ch,
                                 logic [mcpt_pkg::TIME_W-1:0] stamp);
            logic [mcpt_pkg::TIME_W-1:0] period;
            logic [mcpt_pkg::TIME_W-1:0] quotient;
            rev_result_t                 rev;
            if (ch >= mcpt_pkg::CHANNELS)
                return;
            if (pulse_cnt[ch] == ppr) begin
                // Period wraps modulo 2^32 like the free-running timestamp.
                period      = stamp - rev_time[ch];
                rev.channel = ch;
                if (period == '0) begin
                    rev.rpm       = mcpt_pkg::RPM_MAX;
                    rev.saturated = 1'b1;
                end else begin
                    quotient = mcpt_pkg::RPM_NUMERATOR / period;
                    if (quotient > mcpt_pkg::RPM_MAX) begin
                        rev.rpm       = mcpt_pkg::RPM_MAX;
                        rev.saturated = 1'b1;
                    end else begin
                        rev.rpm       = quotient[mcpt_pkg::RPM_W-1:0];
                        rev.saturated = 1'b0;
                    end
                end
                expected_revs.push_back(rev);
                rev_time[ch]  = stamp;
                pulse_cnt[ch] = '0;
            end
            pulse_cnt[ch] = pulse_cnt[ch] + 1'b1;
        endfunction

        function void check_result(logic [mcpt_pkg::CHAN_W-1:0] ch,
                                   logic [mcpt_pkg::RPM_W-1:0] rpm, logic sat);
            rev_result_t want;
            if (expected_revs.size() == 0) begin
                $error("result word for channel %0d with no revolution pending", ch);
                errors++;
                return;
            end
            want = expected_revs.pop_front();
            if (ch !== want.channel) begin
                $error("out_channel: expected %0d, actual %0d", want.channel, ch);
                errors++;
            end
            if (rpm !== want.rpm) begin
                $error("rpm: expected %0d, actual %0d", want.rpm, rpm);
                errors++;
            end
            if (sat !== want.saturated) begin
                $error("saturated: expected %0d, actual %0d", want.saturated, sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_revs.size();
        endfunction
    endclass

    logic                             aclk;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [mcpt_pkg::S_TDATA_W-1:0]   s_tdata   = '0;   // channel, time_us
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [mcpt_pkg::M_TDATA_W-1:0]   m_tdata;          // out_channel, rpm
    logic [0:0]                       m_tuser;          // saturated
    logic                             cfg_we    = 1'b0;
    logic [mcpt_pkg::PPR_W-1:0]       cfg_wdata = '0;

    rpm_scoreboard sb;
    int tx_idle_pct = 10;
    int rx_idle_pct = 10;
    int rx_hold     = 0;
    int cycle_count = 0;

    multi_channel_pulse_tachometer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when rx_hold is loaded.
    initial begin
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[mcpt_pkg::CHAN_W-1:0],
                            m_tdata[mcpt_pkg::CHAN_W +: mcpt_pkg::RPM_W], m_tuser[0]);
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_pulse(input logic [mcpt_pkg::CHAN_W-1:0] ch,
                              input logic [mcpt_pkg::TIME_W-1:0] stamp);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mcpt_pkg::S_TDATA_W'({stamp, ch});
        do @(posedge aclk); while (!s_tready);
        sb.note_pulse(ch, stamp);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_ppr(input logic [mcpt_pkg::PPR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.ppr = value;
    endtask

    initial begin
        logic [mcpt_pkg::PPR_W-1:0]  ppr_val;
        logic [mcpt_pkg::CHAN_W-1:0] ch;
        logic [mcpt_pkg::CHAN_W-1:0] focus;
        logic [mcpt_pkg::TIME_W-1:0] chan_time [mcpt_pkg::CHANNELS];
        bit                          focused;
        int                          phase_words;
        int                          sent;
        int                          pick;

        sb = new();
        foreach (chan_time[i]) chan_time[i] = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With the reset setting, the fifth pulse closes the first revolution,
        // measured from timestamp zero.
        send_pulse(3'd4, 32'd1);
        send_pulse(3'd4, 32'd2);
        send_pulse(3'd4, 32'd3);
        send_pulse(3'd4, 32'd4);
        send_pulse(3'd4, 32'd100000);

        wait_idle();
        write_ppr(8'd1);
        // Zero period, the saturation boundary, rpm of one and zero, largest period.
        send_pulse(3'd0, 32'd0);
        send_pulse(3'd0, 32'd0);
        send_pulse(3'd0, 32'd915);
        send_pulse(3'd0, 32'd1831);
        send_pulse(3'd0, 32'd60001831);
        send_pulse(3'd0, 32'd120001832);
        send_pulse(3'd0, 32'd120001831);
        // Timestamp wrap between revolutions.
        send_pulse(3'd1, 32'hFFFF_0000);
        send_pulse(3'd1, 32'h0001_0000);
        send_pulse(3'd1, 32'hFFFF_FFFF);
        // Channels past the last one are dropped without a result.
        send_pulse(3'd5, $urandom);
        send_pulse(3'd6, $urandom);
        send_pulse(3'd7, 32'hFFFF_FFFF);
        send_pulse(3'd4, 32'hFFFF_FFFF);
        send_pulse(3'd2, 32'h0000_0100);
        send_pulse(3'd2, 32'd1000);
        send_pulse(3'd3, 32'hAAAA_AAAA);
        send_pulse(3'd3, 32'h5555_5555);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ppr_val = 8'd1;
                1: ppr_val = 8'd2;
                2: ppr_val = 8'd255;
                3: ppr_val = 8'd3;
                4: ppr_val = mcpt_pkg::PPR_W'($urandom_range(1, 8));
                5: ppr_val = mcpt_pkg::PPR_W'($urandom_range(1, 255));
                6: ppr_val = 8'd1;
                default: ppr_val = mcpt_pkg::PPR_W'($urandom_range(2, 6));
            endcase
            phase_words = (ppr_val == 8'd255) ? 600 : 200;
            // Long revolutions need most pulses on one channel to finish any.
            focused = (ppr_val > 8'd8);
            focus   = mcpt_pkg::CHAN_W'($urandom_range(0, mcpt_pkg::CHANNELS - 1));

            wait_idle();
            write_ppr(ppr_val);
            tx_idle_pct = (ph == 6) ? 0 : 10;
            rx_idle_pct = (ph == 6) ? 0 : 10;
            if (ph == 0)
                rx_hold = 400;

            sent = 0;
            while (sent < phase_words) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    send_pulse(mcpt_pkg::CHAN_W'($urandom_range(mcpt_pkg::CHANNELS, 7)),
                               $urandom);
                end else begin
                    if (focused && $urandom_range(99) < 85)
                        ch = focus;
                    else
                        ch = mcpt_pkg::CHAN_W'($urandom_range(0, mcpt_pkg::CHANNELS - 1));
                    if (pick < 12) begin
                        chan_time[ch] = $urandom;
                    end else begin
                        case ($urandom_range(3))
                            0: chan_time[ch] += $urandom_range(0, 300);
                            1: chan_time[ch] += $urandom_range(200, 30000);
                            2: chan_time[ch] += $urandom_range(30000, 20000000);
                            default: chan_time[ch] += $urandom;
                        endcase
                    end
                    send_pulse(ch, chan_time[ch]);
                    sent++;
                end
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
